// File: sv/bts_pkg.sv
package bts_pkg;

    // Default texture store dimensions.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 9'd256;

    // Command codes of an input word.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // One texel, red in the upper byte.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } texel_t;

    // Kind of word leaving the coordinate stages.
    typedef struct packed {
        logic sample;
        logic wr_ok;
    } ctl_t;

    // Blend weights in Q0.16.
    typedef struct packed {
        logic [15:0] dx;
        logic [15:0] dy;
    } frac_t;

    // Parity of the four neighbor coordinates, used to pick bank outputs.
    typedef struct packed {
        logic x0_odd;
        logic x1_odd;
        logic y0_odd;
        logic y1_odd;
    } sel_t;

    // Saturate a dimension register to 1..max_dim and return it minus one.
    function automatic logic [12:0] dim_minus_one(input logic [8:0] val,
                                                  input int unsigned max_dim);
        logic [12:0] top_val;
        top_val = 13'(max_dim - 1);
        if (val == 9'd0)
            return 13'd0;
        else if (32'(val) > max_dim)
            return top_val;
        else
            return 13'(val) - 13'd1;
    endfunction

endpackage

// File: sv/bilinear_texture_sampler.sv
// Bilinear texture sampler with repeat wrapping, RGB with 8-bit channels.
//
// Input channel (in_valid / in_stall): a word with cmd low stores one texel
// at texel_col, texel_row; a word with cmd high samples at coord_u, coord_v
// (signed Q16.16) and produces one output word with each channel in Q8.8.
// Output channel (out_valid / out_stall) carries only sample results.
// Configuration: cfg_wr_en with cfg_index selects width or height in use;
// write them only while no word is in flight.
//
// Throughput is one word per cycle while the output is not stalled. The store
// is split into four banks by column and row parity, so each bank's single
// read port serves the 2x2 footprint in one read. Six register stages: A and
// B map coordinates, C reads the banks, D, E and F blend. A texel write lands
// in the bank at the third stage, in order with the samples around it.
// Reset clears the valid bits and sets width and height to 256; the texel
// banks are not cleared and must be loaded before sampling.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// stalls the input only once every stage holds a word.
module bilinear_texture_sampler #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [7:0]                        texel_col,
    input  logic [7:0]                        texel_row,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    input  logic signed [31:0]                coord_u,
    input  logic signed [31:0]                coord_v,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [15:0]                       red_out,
    output logic [15:0]                       green_out,
    output logic [15:0]                       blue_out
);
    import bts_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_DATA_W-1:0]  width_reg;
    logic [CFG_DATA_W-1:0]  height_reg;
    texel_t                 in_texel;
    logic                   b_valid;
    ctl_t                   b_ctl;
    texel_t                 b_texel;
    logic [CW-1:0]          b_col0;
    logic [CW-1:0]          b_col1;
    logic [RW-1:0]          b_row0;
    logic [RW-1:0]          b_row1;
    frac_t                  b_frac;
    logic                   mem_ready;
    logic                   blend_ready;
    logic                   c_valid;
    sel_t                   c_sel;
    frac_t                  c_frac;
    texel_t                 c_q [4];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_DIM_RESET;
            height_reg <= CFG_DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign in_texel.red   = red_in;
    assign in_texel.green = green_in;
    assign in_texel.blue  = blue_in;

    bts_coord #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_coord (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .texel_col  (texel_col),
        .texel_row  (texel_row),
        .texel      (in_texel),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .down_ready (mem_ready),
        .b_valid    (b_valid),
        .b_ctl      (b_ctl),
        .b_texel    (b_texel),
        .b_col0     (b_col0),
        .b_col1     (b_col1),
        .b_row0     (b_row0),
        .b_row1     (b_row1),
        .b_frac     (b_frac)
    );

    bts_texmem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_texmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .b_valid    (b_valid),
        .b_ctl      (b_ctl),
        .b_texel    (b_texel),
        .b_col0     (b_col0),
        .b_col1     (b_col1),
        .b_row0     (b_row0),
        .b_row1     (b_row1),
        .b_frac     (b_frac),
        .up_ready   (mem_ready),
        .down_ready (blend_ready),
        .c_valid    (c_valid),
        .c_sel      (c_sel),
        .c_frac     (c_frac),
        .c_q        (c_q)
    );

    bts_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .c_valid    (c_valid),
        .c_sel      (c_sel),
        .c_frac     (c_frac),
        .c_q        (c_q),
        .up_ready   (blend_ready),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );

    // A free output lets the whole pipeline advance, so the input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output is free");

endmodule

// File: sv/bts_coord.sv
module bts_coord #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [7:0]            texel_col,
    input  logic [7:0]            texel_row,
    input  bts_pkg::texel_t       texel,
    input  logic signed [31:0]    coord_u,
    input  logic signed [31:0]    coord_v,
    input  logic [8:0]            width_cfg,
    input  logic [8:0]            height_cfg,
    input  logic                  down_ready,
    output logic                  b_valid,
    output bts_pkg::ctl_t         b_ctl,
    output bts_pkg::texel_t       b_texel,
    output logic [CW-1:0]         b_col0,
    output logic [CW-1:0]         b_col1,
    output logic [RW-1:0]         b_row0,
    output logic [RW-1:0]         b_row1,
    output bts_pkg::frac_t        b_frac
);
    import bts_pkg::*;

    logic [CW-1:0]      wm1;
    logic [RW-1:0]      hm1;
    logic               en_a;
    logic               en_b;
    logic [16+CW-1:0]   x_prod;
    logic [16:0]        fv_inv;
    logic [17+RW-1:0]   y_prod;

    logic               a_valid_reg;
    logic               a_cmd_reg;
    logic               a_ok_reg;
    logic [CW-1:0]      a_col_reg;
    logic [RW-1:0]      a_row_reg;
    texel_t             a_texel_reg;
    logic [16+CW-1:0]   a_x_reg;
    logic [16+RW-1:0]   a_y_reg;

    logic [CW-1:0]      x0;
    logic [CW-1:0]      x1;
    logic [RW-1:0]      y0;
    logic [RW-1:0]      y1;

    logic               b_valid_reg;
    ctl_t               b_ctl_reg;
    texel_t             b_texel_reg;
    logic [CW-1:0]      b_col0_reg;
    logic [CW-1:0]      b_col1_reg;
    logic [RW-1:0]      b_row0_reg;
    logic [RW-1:0]      b_row1_reg;
    frac_t              b_frac_reg;

    // Largest usable column and row after saturation.
    assign wm1 = CW'(dim_minus_one(width_cfg, MAX_WIDTH));
    assign hm1 = RW'(dim_minus_one(height_cfg, MAX_HEIGHT));

    // Stage advance: a stage moves when empty or when the next one moves.
    assign en_b     = !b_valid_reg || down_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_stall = !en_a;

    // Map the wrapped fractions into texel space; v is flipped.
    assign x_prod = {{CW{1'b0}}, coord_u[15:0]} * {16'd0, wm1};
    assign fv_inv = 17'h10000 - {1'b0, coord_v[15:0]};
    assign y_prod = {{RW{1'b0}}, fv_inv} * {17'd0, hm1};

    // Stage A valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en_a)
            a_valid_reg <= in_valid;
    end

    // Stage A payload.
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_cmd_reg   <= cmd;
            a_ok_reg    <= (32'(texel_col) < MAX_WIDTH) && (32'(texel_row) < MAX_HEIGHT);
            a_col_reg   <= CW'(texel_col);
            a_row_reg   <= RW'(texel_row);
            a_texel_reg <= texel;
            a_x_reg     <= x_prod;
            a_y_reg     <= y_prod[16+RW-1:0];
        end
    end

    // Integer parts and edge-clamped neighbors.
    assign x0 = a_x_reg[16+CW-1:16];
    assign y0 = a_y_reg[16+RW-1:16];
    assign x1 = (x0 == wm1) ? x0 : x0 + 1'b1;
    assign y1 = (y0 == hm1) ? y0 : y0 + 1'b1;

    // Stage B valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en_b)
            b_valid_reg <= a_valid_reg;
    end

    // Stage B payload; a write word carries its address in the first neighbor.
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_ctl_reg.sample <= (a_cmd_reg == CMD_SAMPLE);
            b_ctl_reg.wr_ok  <= a_ok_reg;
            b_texel_reg      <= a_texel_reg;
            b_col0_reg       <= (a_cmd_reg == CMD_SAMPLE) ? x0 : a_col_reg;
            b_row0_reg       <= (a_cmd_reg == CMD_SAMPLE) ? y0 : a_row_reg;
            b_col1_reg       <= x1;
            b_row1_reg       <= y1;
            b_frac_reg.dx    <= a_x_reg[15:0];
            b_frac_reg.dy    <= a_y_reg[15:0];
        end
    end

    assign b_valid = b_valid_reg;
    assign b_ctl   = b_ctl_reg;
    assign b_texel = b_texel_reg;
    assign b_col0  = b_col0_reg;
    assign b_col1  = b_col1_reg;
    assign b_row0  = b_row0_reg;
    assign b_row1  = b_row1_reg;
    assign b_frac  = b_frac_reg;

    // The right neighbor is the same column or the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_ctl_reg.sample) |->
            ((b_col1_reg == b_col0_reg) || (b_col1_reg == CW'(b_col0_reg + 1'b1))))
        else $error("right neighbor is not adjacent to the base column");

endmodule

// File: sv/bts_texmem.sv
module bts_texmem #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              b_valid,
    input  bts_pkg::ctl_t     b_ctl,
    input  bts_pkg::texel_t   b_texel,
    input  logic [CW-1:0]     b_col0,
    input  logic [CW-1:0]     b_col1,
    input  logic [RW-1:0]     b_row0,
    input  logic [RW-1:0]     b_row1,
    input  bts_pkg::frac_t    b_frac,
    output logic              up_ready,
    input  logic              down_ready,
    output logic              c_valid,
    output bts_pkg::sel_t     c_sel,
    output bts_pkg::frac_t    c_frac,
    output bts_pkg::texel_t   c_q [4]
);
    import bts_pkg::*;

    // Four banks split by column and row parity, so the 2x2 footprint
    // touches each bank at most once.
    localparam int BCW = (CW > 1) ? CW - 1 : 1;
    localparam int BRW = (RW > 1) ? RW - 1 : 1;
    localparam int AW  = BCW + BRW;
    localparam int BANK_DEPTH = 1 << AW;

    logic   en_c;
    logic   wr_en;
    logic   c_valid_reg;
    sel_t   c_sel_reg;
    frac_t  c_frac_reg;

    assign en_c     = !c_valid_reg || down_ready;
    assign up_ready = en_c;
    assign wr_en    = en_c && b_valid && !b_ctl.sample && b_ctl.wr_ok;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic RP = ((b / 2) == 1);
        localparam logic CP = ((b % 2) == 1);

        texel_t         mem_arr [BANK_DEPTH];
        texel_t         q_reg;
        logic [RW-1:0]  rd_row;
        logic [CW-1:0]  rd_col;
        logic [AW-1:0]  rd_addr;
        logic [AW-1:0]  wr_addr;
        logic           wr_hit;

        // Each bank reads whichever neighbor has its parity.
        assign rd_row  = (b_row0[0] == RP) ? b_row0 : b_row1;
        assign rd_col  = (b_col0[0] == CP) ? b_col0 : b_col1;
        assign rd_addr = {BRW'(rd_row >> 1), BCW'(rd_col >> 1)};
        assign wr_addr = {BRW'(b_row0 >> 1), BCW'(b_col0 >> 1)};
        assign wr_hit  = (b_row0[0] == RP) && (b_col0[0] == CP);

        // Bank write and registered read; the read word holds while stalled.
        always_ff @(posedge clk)
        begin
            if (wr_en && wr_hit)
                mem_arr[wr_addr] <= b_texel;
            if (en_c)
                q_reg <= mem_arr[rd_addr];
        end

        assign c_q[b] = q_reg;
    end

    // Stage C valid: only samples continue past the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en_c)
            c_valid_reg <= b_valid && b_ctl.sample;
    end

    // Stage C side data.
    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_sel_reg.x0_odd <= b_col0[0];
            c_sel_reg.x1_odd <= b_col1[0];
            c_sel_reg.y0_odd <= b_row0[0];
            c_sel_reg.y1_odd <= b_row1[0];
            c_frac_reg       <= b_frac;
        end
    end

    assign c_valid = c_valid_reg;
    assign c_sel   = c_sel_reg;
    assign c_frac  = c_frac_reg;

endmodule

// File: sv/bts_blend.sv
module bts_blend (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              c_valid,
    input  bts_pkg::sel_t     c_sel,
    input  bts_pkg::frac_t    c_frac,
    input  bts_pkg::texel_t   c_q [4],
    output logic              up_ready,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [15:0]       red_out,
    output logic [15:0]       green_out,
    output logic [15:0]       blue_out
);
    import bts_pkg::*;

    logic           en_d;
    logic           en_e;
    logic           en_f;
    texel_t         t00;
    texel_t         t10;
    texel_t         t01;
    texel_t         t11;
    logic [16:0]    wdx;
    logic [16:0]    wdy;
    logic [23:0]    r0_next [3];
    logic [23:0]    r1_next [3];
    logic [40:0]    sum [3];

    logic           d_valid_reg;
    logic [23:0]    d_r0_reg [3];
    logic [23:0]    d_r1_reg [3];
    logic [15:0]    d_dy_reg;
    logic           e_valid_reg;
    logic [40:0]    e_p0_reg [3];
    logic [40:0]    e_p1_reg [3];
    logic           f_valid_reg;
    logic [15:0]    f_out_reg [3];

    assign en_f     = !f_valid_reg || !out_stall;
    assign en_e     = !e_valid_reg || en_f;
    assign en_d     = !d_valid_reg || en_e;
    assign up_ready = en_d;

    // Pick the four neighbors from the banks by their parities.
    assign t00 = c_q[{c_sel.y0_odd, c_sel.x0_odd}];
    assign t10 = c_q[{c_sel.y0_odd, c_sel.x1_odd}];
    assign t01 = c_q[{c_sel.y1_odd, c_sel.x0_odd}];
    assign t11 = c_q[{c_sel.y1_odd, c_sel.x1_odd}];
    assign wdx = 17'h10000 - {1'b0, c_frac.dx};

    // Horizontal blend of both rows, exact in Q.16.
    always_comb
    begin
        logic [24:0] a0;
        logic [24:0] a1;
        for (int ch = 0; ch < 3; ch++)
        begin
            a0 = 25'(t00[23-8*ch -: 8]) * 25'(wdx) + 25'(t10[23-8*ch -: 8]) * 25'(c_frac.dx);
            a1 = 25'(t01[23-8*ch -: 8]) * 25'(wdx) + 25'(t11[23-8*ch -: 8]) * 25'(c_frac.dx);
            r0_next[ch] = a0[23:0];
            r1_next[ch] = a1[23:0];
        end
    end

    assign wdy = 17'h10000 - {1'b0, d_dy_reg};

    // Vertical blend sum and round half up to 8 fraction bits.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            sum[ch] = e_p0_reg[ch] + e_p1_reg[ch] + 41'h800000;
    end

    // Valid bits of stages D, E and F.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_d)
                d_valid_reg <= c_valid;
            if (en_e)
                e_valid_reg <= d_valid_reg;
            if (en_f)
                f_valid_reg <= e_valid_reg;
        end
    end

    // Payload of stages D, E and F.
    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_r0_reg <= r0_next;
            d_r1_reg <= r1_next;
            d_dy_reg <= c_frac.dy;
        end
        if (en_e)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                e_p0_reg[ch] <= {17'd0, d_r0_reg[ch]} * {24'd0, wdy};
                e_p1_reg[ch] <= {17'd0, d_r1_reg[ch]} * {24'd0, 1'b0, d_dy_reg};
            end
        end
        if (en_f)
        begin
            for (int ch = 0; ch < 3; ch++)
                f_out_reg[ch] <= sum[ch][39:24];
        end
    end

    assign out_valid = f_valid_reg;
    assign red_out   = f_out_reg[0];
    assign green_out = f_out_reg[1];
    assign blue_out  = f_out_reg[2];

    // A result waiting on the receiver is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid_reg && out_stall) |=> f_valid_reg)
        else $error("stalled result was lost");

    // A blend of 8-bit texels never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |-> ((red_out <= 16'hFF00) && (green_out <= 16'hFF00)
                         && (blue_out <= 16'hFF00)))
        else $error("blended channel above full scale");

    // A word in stage E moves on whenever stage F is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !f_valid_reg) |=> f_valid_reg)
        else $error("word stuck in stage E with an empty output");

endmodule

// File: tb/tb_bilinear_texture_sampler.sv
module tb_bilinear_texture_sampler;

    import bts_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_WORDS  = 130;
    localparam int HOLD_CYCLES  = 80;

    // One input word as the sender offers it.
    typedef struct packed {
        logic              cmd;
        logic [7:0]        col;
        logic [7:0]        row;
        texel_t            color;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } sampler_word_t;

    // One interpolated color, each channel in Q8.8.
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } color_q8_t;

    // Tracks the texture and the dimensions, predicts every sample and
    // compares the output words against those predictions in order.
    class sample_scoreboard;
        bit [23:0]   texels [65536];
        bit          written [65536];
        logic [8:0]  width_reg;
        logic [8:0]  height_reg;
        color_q8_t   expected_colors [$];
        int unsigned fails;

        function new();
            width_reg  = CFG_DIM_RESET;
            height_reg = CFG_DIM_RESET;
            fails      = 0;
        endfunction

        // A zero dimension acts as one, anything past the store as its size.
        static function longint unsigned clamp_dim(logic [8:0] val, int unsigned max_dim);
            if (val == 9'd0)
                return 1;
            if (32'(val) > max_dim)
                return max_dim;
            return val;
        endfunction

        // Two row blends in Q.16, then the column blend in Q.32, rounded to Q8.8.
        function logic [15:0] mix(logic [7:0] c00, logic [7:0] c10, logic [7:0] c01,
                                  logic [7:0] c11, longint unsigned dx, longint unsigned dy);
            longint unsigned r0;
            longint unsigned r1;
            longint unsigned acc;
            r0  = c00 * (64'd65536 - dx) + c10 * dx;
            r1  = c01 * (64'd65536 - dx) + c11 * dx;
            acc = r0 * (64'd65536 - dy) + r1 * dy;
            return 16'((acc + 64'd8388608) >> 24);
        endfunction

        function color_q8_t blend_sample(logic [31:0] u, logic [31:0] v);
            longint unsigned w;
            longint unsigned h;
            longint unsigned x;
            longint unsigned y;
            longint unsigned x0;
            longint unsigned y0;
            longint unsigned x1;
            longint unsigned y1;
            texel_t          t00;
            texel_t          t10;
            texel_t          t01;
            texel_t          t11;
            color_q8_t       res;
            w  = clamp_dim(width_reg, DEF_MAX_WIDTH);
            h  = clamp_dim(height_reg, DEF_MAX_HEIGHT);
            // The vertical axis is flipped, so a zero fraction lands on the last row.
            x  = 64'(u[15:0]) * (w - 1);
            y  = (64'd65536 - 64'(v[15:0])) * (h - 1);
            x0 = x >> 16;
            y0 = y >> 16;
            x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
            if (x0 > w - 1)
                x0 = w - 1;
            if (y0 > h - 1)
                y0 = h - 1;
            t00 = texels[{y0[7:0], x0[7:0]}];
            t10 = texels[{y0[7:0], x1[7:0]}];
            t01 = texels[{y1[7:0], x0[7:0]}];
            t11 = texels[{y1[7:0], x1[7:0]}];
            res.red   = mix(t00.red, t10.red, t01.red, t11.red, x & 'hFFFF, y & 'hFFFF);
            res.green = mix(t00.green, t10.green, t01.green, t11.green,
                            x & 'hFFFF, y & 'hFFFF);
            res.blue  = mix(t00.blue, t10.blue, t01.blue, t11.blue, x & 'hFFFF, y & 'hFFFF);
            return res;
        endfunction

        // True when all four neighbors of a sample hold a written texel.
        function bit covers(logic [31:0] u, logic [31:0] v);
            longint unsigned w;
            longint unsigned h;
            longint unsigned x0;
            longint unsigned y0;
            longint unsigned x1;
            longint unsigned y1;
            w  = clamp_dim(width_reg, DEF_MAX_WIDTH);
            h  = clamp_dim(height_reg, DEF_MAX_HEIGHT);
            x0 = (64'(u[15:0]) * (w - 1)) >> 16;
            y0 = ((64'd65536 - 64'(v[15:0])) * (h - 1)) >> 16;
            x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
            return written[{y0[7:0], x0[7:0]}] && written[{y0[7:0], x1[7:0]}]
                   && written[{y1[7:0], x0[7:0]}] && written[{y1[7:0], x1[7:0]}];
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_WIDTH)
                width_reg = data;
            else if (idx == CFG_HEIGHT)
                height_reg = data;
        endfunction

        // A texel write updates the texture; a sample queues its color.
        function void note_word(sampler_word_t wd);
            if (wd.cmd == CMD_WRITE)
            begin
                texels[{wd.row, wd.col}]  = wd.color;
                written[{wd.row, wd.col}] = 1'b1;
            end
            else
                expected_colors.insert(expected_colors.size(), blend_sample(wd.u, wd.v));
        endfunction

        function void check_result(color_q8_t got);
            color_q8_t want;
            if (expected_colors.size() == 0)
            begin
                $error("output word arrived with no sample waiting");
                fails++;
                return;
            end
            want = expected_colors.pop_front();
            if (got.red !== want.red)
            begin
                $error("red_out: expected %0d, got %0d", want.red, got.red);
                fails++;
            end
            if (got.green !== want.green)
            begin
                $error("green_out: expected %0d, got %0d", want.green, got.green);
                fails++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                fails++;
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [7:0]            texel_col;
    logic [7:0]            texel_row;
    logic [7:0]            red_in;
    logic [7:0]            green_in;
    logic [7:0]            blue_in;
    logic signed [31:0]    coord_u;
    logic signed [31:0]    coord_v;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [15:0]           red_out;
    logic [15:0]           green_out;
    logic [15:0]           blue_out;

    sample_scoreboard sb;
    int unsigned      gap_pct = 0;
    int unsigned      stall_pct = 0;
    int unsigned      hold_request = 0;
    int unsigned      hold_seen = 0;
    int unsigned      hold_left = 0;
    int unsigned      cycle_count = 0;
    int unsigned      dim_w = 256;
    int unsigned      dim_h = 256;

    bilinear_texture_sampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .texel_col (texel_col),
        .texel_row (texel_row),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .coord_u   (coord_u),
        .coord_v   (coord_v),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch all three ports at the rising edge and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.note_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_word({cmd, texel_col, texel_row, red_in, green_in, blue_in,
                              coord_u, coord_v});
            if (out_valid && !out_stall)
                sb.check_result({red_out, green_out, blue_out});
        end
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** bilinear_texture_sampler: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Fractions near the texel grid edges turn up more often than chance.
    function automatic logic [15:0] random_fraction();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'($urandom_range(0, 255));
            4: return 16'hFFFF - 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    // Every field is filled, so the ones the command ignores carry noise too.
    function automatic sampler_word_t random_word();
        sampler_word_t wd;
        int unsigned   tries;
        wd.cmd = ($urandom_range(0, 99) < 30) ? CMD_WRITE : CMD_SAMPLE;
        if ($urandom_range(0, 1) == 1)
        begin
            wd.col = 8'($urandom_range(0, dim_w - 1));
            wd.row = 8'($urandom_range(0, dim_h - 1));
        end
        else
        begin
            wd.col = 8'($urandom());
            wd.row = 8'($urandom());
        end
        wd.color = {random_channel(), random_channel(), random_channel()};
        wd.u     = {16'($urandom()), random_fraction()};
        wd.v     = {16'($urandom()), random_fraction()};
        // A sample only reads texels that are already loaded; the origin
        // block serves as the fallback footprint.
        tries = 0;
        while (wd.cmd == CMD_SAMPLE && !sb.covers(wd.u, wd.v) && tries < 64)
        begin
            wd.u = {16'($urandom()), random_fraction()};
            wd.v = {16'($urandom()), random_fraction()};
            tries++;
        end
        if (wd.cmd == CMD_SAMPLE && !sb.covers(wd.u, wd.v))
        begin
            wd.u[15:0] = 16'h0000;
            wd.v[15:0] = 16'hFFFF;
        end
        return wd;
    endfunction

    // Offer one word after a random gap; return at the falling edge after it is taken.
    task automatic send_word(sampler_word_t wd);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= wd.cmd;
        texel_col <= wd.col;
        texel_row <= wd.row;
        red_in    <= wd.color.red;
        green_in  <= wd.color.green;
        blue_in   <= wd.color.blue;
        coord_u   <= wd.u;
        coord_v   <= wd.v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_texel(logic [7:0] col, logic [7:0] row, texel_t color);
        sampler_word_t wd;
        wd       = random_word();
        wd.cmd   = CMD_WRITE;
        wd.col   = col;
        wd.row   = row;
        wd.color = color;
        send_word(wd);
    endtask

    task automatic send_sample(logic [31:0] u, logic [31:0] v);
        sampler_word_t wd;
        wd     = random_word();
        wd.cmd = CMD_SAMPLE;
        wd.u   = u;
        wd.v   = v;
        send_word(wd);
    endtask

    task automatic write_dims(logic [8:0] w, logic [8:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        dim_w = 32'(sample_scoreboard::clamp_dim(w, DEF_MAX_WIDTH));
        dim_h = 32'(sample_scoreboard::clamp_dim(h, DEF_MAX_HEIGHT));
    endtask

    // Wait for the last sample, then let trailing texel writes settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int          p;
        int unsigned r;
        int unsigned c;
        logic [8:0]  w_set;
        logic [8:0]  h_set;
        bit          hold;

        sb        = new();
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        cmd       = CMD_WRITE;
        texel_col = '0;
        texel_row = '0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        coord_u   = '0;
        coord_v   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load every texel whose row and column each lie in 0..15 or 248..255,
        // so samples at every wrap extreme find written texels.
        for (r = 0; r < 24; r++)
            for (c = 0; c < 24; c++)
                send_texel(8'((c < 16) ? c : c + 232), 8'((r < 16) ? r : r + 232),
                           {random_channel(), random_channel(), random_channel()});

        // Directed words: fraction extremes, integer and negative coordinates,
        // corner texels at the channel extremes, and a write followed at once
        // by a sample that reads it.
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0000_FFFF, 32'h0000_FFFF);
        // The midpoint sample reads the four texels around the store center.
        for (r = 127; r < 129; r++)
            for (c = 127; c < 129; c++)
                send_texel(8'(c), 8'(r), {random_channel(), random_channel(), random_channel()});
        send_sample(32'h0000_8000, 32'h0000_8000);
        send_sample(32'hFFFF_FFFF, 32'h8000_0000);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h0001_0000);
        send_sample(32'hFFFF_0001, 32'h0000_0001);
        send_texel(8'd0, 8'd0, 24'hFFFFFF);
        send_sample(32'h0000_0000, 32'h0000_FFFF);
        send_texel(8'd255, 8'd255, 24'h00FF00);
        send_sample(32'h0000_FFFF, 32'h0000_0000);
        send_texel(8'd0, 8'd255, 24'h000000);
        send_texel(8'd255, 8'd0, 24'hFFFFFF);
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0000_FFFF, 32'h0000_FFFF);
        send_sample(32'h1234_0100, 32'hFEDC_FF00);
        wait_idle();

        // Random phases, each with its own dimensions and idling pattern.
        for (p = 0; p < 8; p++)
        begin
            hold = 1'b0;
            case (p)
                0:
                begin
                    w_set = 9'd1;   h_set = 9'd1;   gap_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    w_set = 9'd2;   h_set = 9'd2;   gap_pct = 54; stall_pct = 0;
                end
                2:
                begin
                    w_set = 9'd0;   h_set = 9'd511; gap_pct = 0;  stall_pct = 54;
                end
                3:
                begin
                    w_set = 9'd256; h_set = 9'd256; gap_pct = 7;  stall_pct = 7;
                end
                4:
                begin
                    w_set = 9'd511; h_set = 9'd0;   gap_pct = 0;  stall_pct = 0;
                    hold  = 1'b1;
                end
                5:
                begin
                    w_set = 9'($urandom_range(2, 16));
                    h_set = 9'($urandom_range(2, 16));
                    gap_pct = 54; stall_pct = 0;
                end
                6:
                begin
                    w_set = 9'($urandom_range(1, 256));
                    h_set = 9'($urandom_range(1, 256));
                    gap_pct = 0;  stall_pct = 54;
                end
                default:
                begin
                    w_set = 9'($urandom_range(0, 511));
                    h_set = 9'($urandom_range(0, 511));
                    gap_pct = 7;  stall_pct = 7;
                    hold  = 1'b1;
                end
            endcase
            write_dims(w_set, h_set);
            // Hold the receiver off while words keep coming, so the pipe fills.
            if (hold)
            begin
                @(posedge clk);
                hold_request++;
                @(negedge clk);
            end
            repeat (PHASE_WORDS) send_word(random_word());
            wait_idle();
        end

        if (sb.fails == 0 && sb.pending() == 0)
            $display("** bilinear_texture_sampler: PASSED **");
        else
            $display("** bilinear_texture_sampler: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
sv/bts_pkg.sv
sv/bts_coord.sv
sv/bts_texmem.sv
sv/bts_blend.sv
sv/bilinear_texture_sampler.sv
tb/tb_bilinear_texture_sampler.sv
